@@ rtl/hnrf_pkg.sv @@
// Shared types and constants for the H.264 NAL to RTP fragmenter.
// Used by every module under rtl/; depends on nothing else.
package hnrf_pkg;

    localparam int unsigned PAYLOAD_CAP   = 1500;
    localparam int unsigned CMD_DEPTH     = 4;
    localparam int unsigned CMD_PTR_W     = $clog2(CMD_DEPTH);
    localparam int unsigned OUT_DEPTH     = 2;
    localparam int unsigned OUT_PTR_W     = $clog2(OUT_DEPTH);

    localparam logic [7:0] FU_A_TYPE      = 8'd28;
    localparam logic [7:0] NRI_MASK       = 8'h60;
    localparam logic [7:0] TYPE_MASK      = 8'h1F;
    localparam logic [7:0] FU_START_BIT   = 8'h80;
    localparam logic [7:0] FU_END_BIT     = 8'h40;
    localparam logic [4:0] NAL_TYPE_SEI   = 5'd6;
    localparam logic [4:0] NAL_TYPE_SPS   = 5'd7;
    localparam logic [4:0] NAL_TYPE_PPS   = 5'd8;

    localparam logic [10:0] MAX_PAYLOAD_RESET = 11'd1400;
    localparam logic [16:0] TS_STEP_RESET     = 17'd3600;

    typedef enum logic [0:0] {
        CFG_MAX_PAYLOAD = 1'b0,
        CFG_TS_STEP     = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [7:0]  nal_byte;
        logic        nal_first;
        logic [15:0] nal_size;
    } nal_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        packet_start;
        logic        packet_end;
        logic [10:0] packet_length;
        logic        marker_bit;
        logic [15:0] sequence_number;
        logic [31:0] timestamp;
    } rtp_item_t;

    // One classified data byte; fu marks a byte that opens a fragment.
    typedef struct packed {
        logic        fu;
        logic [7:0]  fu_indicator;
        logic [7:0]  fu_header;
        rtp_item_t   data;
    } cmd_t;

endpackage

@@ rtl/hnrf_front.sv @@
// Front end: config registers, per-unit state and classification of each byte.
// Depends on hnrf_pkg.
module hnrf_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   take,
    input  hnrf_pkg::nal_item_t    nal,
    input  logic                   cfg_write,
    input  hnrf_pkg::cfg_index_t   cfg_index,
    input  logic [16:0]            cfg_data,
    output logic                   cmd_push,
    output hnrf_pkg::cmd_t         cmd
);
    import hnrf_pkg::*;

    logic [10:0] max_payload_reg;
    logic [16:0] ts_step_reg;
    logic [15:0] seq_reg, seq_next;
    logic [31:0] time_reg, time_next;
    logic [7:0]  hdr_reg, hdr_next;
    logic [15:0] left_reg, left_next;
    logic [10:0] fill_reg, fill_next;
    logic        fmode_reg, fmode_next;
    logic        ffirst_reg, ffirst_next;

    logic [10:0] m;
    logic [15:0] size_eff;
    logic [15:0] left_eff;
    logic [10:0] fill_eff;
    logic        fmode_eff;
    logic        ffirst_eff;
    logic [7:0]  hdr_eff;
    logic        produce;
    logic [16:0] total;
    logic [16:0] len;
    logic        marker;
    logic [10:0] plen;
    logic        fu;
    logic        last;
    logic [4:0]  nal_type;
    logic        skip_ts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
            ts_step_reg     <= TS_STEP_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MAX_PAYLOAD: max_payload_reg <= cfg_data[10:0];
                CFG_TS_STEP:     ts_step_reg     <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        m = max_payload_reg;
        if (m == 11'd0)
            m = 11'd1;
        else if (m > 11'(PAYLOAD_CAP))
            m = 11'(PAYLOAD_CAP);
    end

    always_comb
    begin
        size_eff   = (nal.nal_size == 16'd0) ? 16'd1 : nal.nal_size;
        left_eff   = left_reg;
        fill_eff   = fill_reg;
        fmode_eff  = fmode_reg;
        ffirst_eff = ffirst_reg;
        hdr_eff    = hdr_reg;
        produce    = (left_reg != 16'd0);
        if (nal.nal_first)
        begin
            hdr_eff  = nal.nal_byte;
            fill_eff = 11'd0;
            if (size_eff <= {5'd0, m})
            begin
                fmode_eff = 1'b0;
                left_eff  = size_eff;
                produce   = 1'b1;
            end
            else
            begin
                // the header byte of a fragmented unit is dropped
                fmode_eff  = 1'b1;
                ffirst_eff = 1'b1;
                left_eff   = size_eff - 16'd1;
                produce    = 1'b0;
            end
        end

        total  = {1'b0, left_eff} + {6'd0, fill_eff};
        len    = (fmode_eff && total > {6'd0, m}) ? {6'd0, m} : total;
        if (len == 17'd0)
            len = 17'd1;
        marker = fmode_eff && (total <= {6'd0, m});
        plen   = fmode_eff ? (len[10:0] + 11'd2) : len[10:0];
        fu     = fmode_eff && (fill_eff == 11'd0);
        last   = ({6'd0, fill_eff} + 17'd1) >= len;

        nal_type = hdr_eff[4:0];
        skip_ts  = !fmode_eff && (nal_type inside {NAL_TYPE_SEI, NAL_TYPE_SPS, NAL_TYPE_PPS});
    end

    // next state
    always_comb
    begin
        seq_next    = seq_reg;
        time_next   = time_reg;
        hdr_next    = hdr_reg;
        left_next   = left_reg;
        fill_next   = fill_reg;
        fmode_next  = fmode_reg;
        ffirst_next = ffirst_reg;
        if (take)
        begin
            hdr_next    = hdr_eff;
            left_next   = left_eff;
            fill_next   = fill_eff;
            fmode_next  = fmode_eff;
            ffirst_next = ffirst_eff;
            if (produce)
            begin
                if (fu)
                    ffirst_next = 1'b0;
                left_next = left_eff - 16'd1;
                fill_next = fill_eff + 11'd1;
                if (last)
                begin
                    seq_next  = seq_reg + 16'd1;
                    fill_next = 11'd0;
                end
                if (left_next == 16'd0)
                begin
                    if (!skip_ts)
                        time_next = time_reg + {15'd0, ts_step_reg};
                    fill_next = 11'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg    <= '0;
            time_reg   <= '0;
            hdr_reg    <= '0;
            left_reg   <= '0;
            fill_reg   <= '0;
            fmode_reg  <= 1'b0;
            ffirst_reg <= 1'b0;
        end
        else
        begin
            seq_reg    <= seq_next;
            time_reg   <= time_next;
            hdr_reg    <= hdr_next;
            left_reg   <= left_next;
            fill_reg   <= fill_next;
            fmode_reg  <= fmode_next;
            ffirst_reg <= ffirst_next;
        end
    end

    // classified command for the back end
    always_comb
    begin
        cmd_push                  = take && produce;
        cmd.fu                    = fu;
        cmd.fu_indicator          = (hdr_eff & NRI_MASK) | FU_A_TYPE;
        cmd.fu_header             = (hdr_eff & TYPE_MASK)
                                  | (ffirst_eff ? FU_START_BIT : 8'h00)
                                  | (marker ? FU_END_BIT : 8'h00);
        cmd.data.out_byte         = nal.nal_byte;
        cmd.data.packet_start     = !fmode_eff && (fill_eff == 11'd0);
        cmd.data.packet_end       = last;
        cmd.data.packet_length    = plen;
        cmd.data.marker_bit       = marker;
        cmd.data.sequence_number  = seq_reg;
        cmd.data.timestamp        = time_reg;
    end

endmodule

@@ rtl/hnrf_cmd_fifo.sv @@
// Short command queue between front and back end.
// Depends on hnrf_pkg.
module hnrf_cmd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  hnrf_pkg::cmd_t  wr_data,
    input  logic            rd,
    output hnrf_pkg::cmd_t  rd_data,
    output logic            full,
    output logic            empty
);
    import hnrf_pkg::*;

    cmd_t                 mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wptr_reg, wptr_next;
    logic [CMD_PTR_W-1:0] rptr_reg, rptr_next;
    logic [CMD_PTR_W:0]   count_reg, count_next;
    logic                 do_wr, do_rd;

    assign full    = (count_reg == (CMD_PTR_W+1)'(CMD_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = mem[rptr_reg];

    always_comb
    begin
        wptr_next  = do_wr ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = do_rd ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + (CMD_PTR_W+1)'(do_wr) - (CMD_PTR_W+1)'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/hnrf_back.sv @@
// Back end: expands each command into one or three payload bytes and
// holds them in a two-entry result queue. Depends on hnrf_pkg.
module hnrf_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hnrf_pkg::cmd_t       cmd,
    input  logic                 cmd_empty,
    output logic                 cmd_pop,
    input  logic                 pop,
    output logic                 empty,
    output hnrf_pkg::rtp_item_t  rtp
);
    import hnrf_pkg::*;

    rtp_item_t            mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wptr_reg, wptr_next;
    logic [OUT_PTR_W-1:0] rptr_reg, rptr_next;
    logic [OUT_PTR_W:0]   count_reg, count_next;
    logic [1:0]           phase_reg, phase_next;
    logic                 out_full;
    logic                 emit;
    logic                 last;
    logic                 do_rd;
    rtp_item_t            item;

    assign out_full = (count_reg == (OUT_PTR_W+1)'(OUT_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_rd    = pop && !empty;
    assign rtp      = mem[rptr_reg];
    assign emit     = !cmd_empty && !out_full;
    assign last     = !cmd.fu || (phase_reg == 2'd2);
    assign cmd_pop  = emit && last;

    // FU indicator, then FU header, then the data byte
    always_comb
    begin
        item = cmd.data;
        if (cmd.fu && phase_reg == 2'd0)
        begin
            item.out_byte     = cmd.fu_indicator;
            item.packet_start = 1'b1;
            item.packet_end   = 1'b0;
        end
        else if (cmd.fu && phase_reg == 2'd1)
        begin
            item.out_byte     = cmd.fu_header;
            item.packet_start = 1'b0;
            item.packet_end   = 1'b0;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (emit)
            phase_next = last ? 2'd0 : phase_reg + 2'd1;
        wptr_next  = emit ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = do_rd ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + (OUT_PTR_W+1)'(emit) - (OUT_PTR_W+1)'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            mem[wptr_reg] <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/h264_nal_rtp_fragmenter.sv @@
// H.264 NAL unit to RTP payload packetizer (single packets and FU-A).
// With both queues empty, the first result of an accepted byte goes through the
// command queue and then the result queue before it is on the result ports.
// Throughput: 1 byte per cycle while full is low; a byte that opens a fragment
// gives three results at the back end: the FU indicator, FU header and the byte itself.
// Reset (rst_n, async, active low) empties both queues and zeroes counters.
module h264_nal_rtp_fragmenter (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  hnrf_pkg::nal_item_t   nal,
    output logic                  empty,
    input  logic                  pop,
    output hnrf_pkg::rtp_item_t   rtp,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  hnrf_pkg::cfg_index_t  cfg_index,
    input  logic [16:0]           cfg_data
);
    import hnrf_pkg::*;

    cmd_t cmd_in, cmd_out;
    logic cmd_push, cmd_pop, cmd_full, cmd_empty;
    logic take;

    assign cfg_ready = 1'b1;
    assign full      = cmd_full;
    assign take      = push && !cmd_full;

    hnrf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .nal       (nal),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in)
    );

    hnrf_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (cmd_push),
        .wr_data (cmd_in),
        .rd      (cmd_pop),
        .rd_data (cmd_out),
        .full    (cmd_full),
        .empty   (cmd_empty)
    );

    hnrf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .rtp       (rtp)
    );

endmodule

@@ rtl/hnrf_checker.sv @@
// Port-level checks for h264_nal_rtp_fragmenter, bound to the top level.
// Depends on hnrf_pkg.
module hnrf_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 empty,
    input logic                 pop,
    input hnrf_pkg::rtp_item_t  rtp
);
    import hnrf_pkg::*;

    // hold a waiting result until it is popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(rtp)))
        else $error("result changed while waiting");

    a_start_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rtp.packet_start && rtp.packet_end) |-> (rtp.packet_length == 11'd1))
        else $error("packet both starts and ends with length above one");

    a_marker_len: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rtp.marker_bit) |-> (rtp.packet_length >= 11'd3))
        else $error("marked fragment shorter than its FU bytes");

    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(rst_n) == 1'b0) |-> empty)
        else $error("result queue not empty after reset");

endmodule

bind h264_nal_rtp_fragmenter hnrf_checker u_hnrf_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .empty (empty),
    .pop   (pop),
    .rtp   (rtp)
);
